FILE: src/tempc_pkg.sv
// Shared constants, types and the resistance ROM for the thermistor converter.
package tempc_pkg;

  localparam int SERIES_W          = 16;
  localparam int MV_W              = 12;
  localparam int TEMP_W            = 12;
  localparam int STATUS_W          = 2;
  localparam int ROM_SIZE          = 136;
  localparam int ROM_W             = 17;
  localparam int ROM_IW            = 8;
  localparam int TEMP_FIRST_C      = -30;
  localparam int TABLE_ENTRIES_DEF = 136;
  localparam int FRACTION_BITS_DEF = 8;
  localparam logic [SERIES_W-1:0] SERIES_RESET = 16'd8250;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_BELOW = 2'd1,
    ST_ABOVE = 2'd2,
    ST_ZERO  = 2'd3
  } status_t;

  // per-request control that travels with the data
  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

  // thermistor resistance in ohms, -30 C first, one degree per entry
  localparam logic [ROM_W-1:0] RES_ROM [ROM_SIZE] = '{
    17'd113347, 17'd107565, 17'd102116, 17'd96978, 17'd92132, 17'd87559,
    17'd83242, 17'd79166, 17'd75316, 17'd71677,
    17'd68237, 17'd64991, 17'd61919, 17'd59011, 17'd56258, 17'd53650,
    17'd51178, 17'd48835, 17'd46613, 17'd44506,
    17'd42506, 17'd40600, 17'd38791, 17'd37073, 17'd35442, 17'd33892,
    17'd32420, 17'd31020, 17'd29689, 17'd28423,
    17'd27219, 17'd26076, 17'd24988, 17'd23951, 17'd22963, 17'd22021,
    17'd21123, 17'd20267, 17'd19450, 17'd18670,
    17'd17926, 17'd17214, 17'd16534, 17'd15886, 17'd15266, 17'd14674,
    17'd14108, 17'd13566, 17'd13049, 17'd12554,
    17'd12081, 17'd11628, 17'd11195, 17'd10780, 17'd10382, 17'd10000,
    17'd9634, 17'd9284, 17'd8947, 17'd8624,
    17'd8315, 17'd8018, 17'd7734, 17'd7461, 17'd7199, 17'd6948,
    17'd6707, 17'd6475, 17'd6253, 17'd6039,
    17'd5834, 17'd5636, 17'd5445, 17'd5262, 17'd5086, 17'd4917,
    17'd4754, 17'd4597, 17'd4446, 17'd4301,
    17'd4161, 17'd4026, 17'd3896, 17'd3771, 17'd3651, 17'd3535,
    17'd3423, 17'd3315, 17'd3211, 17'd3111,
    17'd3014, 17'd2922, 17'd2834, 17'd2748, 17'd2666, 17'd2586,
    17'd2509, 17'd2435, 17'd2364, 17'd2294,
    17'd2228, 17'd2163, 17'd2100, 17'd2040, 17'd1981, 17'd1925,
    17'd1870, 17'd1817, 17'd1766, 17'd1716,
    17'd1669, 17'd1622, 17'd1578, 17'd1535, 17'd1493, 17'd1452,
    17'd1413, 17'd1375, 17'd1338, 17'd1303,
    17'd1268, 17'd1234, 17'd1202, 17'd1170, 17'd1139, 17'd1110,
    17'd1081, 17'd1053, 17'd1026, 17'd999,
    17'd974, 17'd949, 17'd925, 17'd902, 17'd880, 17'd858
  };

  function automatic logic [ROM_W-1:0] rom_entry(input logic [ROM_IW-1:0] idx);
    logic [ROM_W-1:0] v;
    v = '0;
    if (int'(idx) < ROM_SIZE) begin
      v = RES_ROM[idx];
    end
    return v;
  endfunction

endpackage

FILE: src/thermistor_temperature_convert_unit.sv
// Top level of the NTC thermistor temperature converter.
//
// Converts a pair of divider voltages (supply and thermistor tap, in mV) into
// a temperature in tenths of a degree C. The thermistor resistance is
// series*supply/tap - series with FRACTION_BITS fraction bits; it is located
// in a 136-entry descending resistance table (-30 C .. 105 C, one degree per
// entry) and interpolated linearly, then rounded by adding half a tenth and
// truncating toward zero. Results outside the table saturate at the first or
// last table temperature with status "below range" (1) or "above range" (2);
// a zero tap voltage gives status 3 with temperature 0.
// Throughput is one request per cycle while the output is not stalled. The
// divider retires four quotient bits per stage and the table search one index
// bit per stage. The whole pipeline holds while a finished result sits stalled
// at the output; bubbles inside the pipeline are not squeezed out. The series
// resistance register (reset 8250 ohms) is written through the cfg port, which
// is always ready; write it only while no request is in flight.
module thermistor_temperature_convert_unit #(
  parameter int TABLE_ENTRIES = tempc_pkg::TABLE_ENTRIES_DEF,
  parameter int FRACTION_BITS = tempc_pkg::FRACTION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [tempc_pkg::MV_W-1:0]           in_supply_mv,
  input  logic [tempc_pkg::MV_W-1:0]           in_sensor_mv,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [tempc_pkg::TEMP_W-1:0]  out_temp_tenths,
  output logic [tempc_pkg::STATUS_W-1:0]       out_status,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tempc_pkg::SERIES_W-1:0]       cfg_series_resistance
);
  import tempc_pkg::*;

  localparam int COUNT = (TABLE_ENTRIES < ROM_SIZE) ? TABLE_ENTRIES : ROM_SIZE;
  localparam int SB    = $clog2(COUNT + 1);
  localparam int PW    = SERIES_W + MV_W;
  localparam int NW    = PW + FRACTION_BITS;
  localparam int RW    = ROM_W + FRACTION_BITS;

  // pipeline advances unless a result is waiting and stalled
  logic en;
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // series resistance register
  logic [SERIES_W-1:0] series_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      series_r <= SERIES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      series_r <= cfg_series_resistance;
    end
  end

  // stage 0: series * supply
  ctl_t                ctl0_r;
  logic [PW-1:0]       prod_r;
  logic [MV_W-1:0]     tap_r;
  logic [SERIES_W-1:0] ser0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else if (en) begin
      ctl0_r.valid <= in_valid;
      ctl0_r.zero  <= (in_sensor_mv == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PW'(series_r * in_supply_mv);
      tap_r  <= in_sensor_mv;
      ser0_r <= series_r;
    end
  end

  // quotient of (series * supply) << FRACTION_BITS by the tap voltage
  ctl_t                ctl_div;
  logic [NW-1:0]       quo;
  logic [SERIES_W-1:0] ser_div;

  tempc_div #(
    .NW     (NW),
    .DW     (MV_W),
    .SIDE_W (SERIES_W),
    .K      (4)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_ctl   (ctl0_r),
    .in_num   (NW'(prod_r) << FRACTION_BITS),
    .in_den   (tap_r),
    .in_side  (ser0_r),
    .out_ctl  (ctl_div),
    .out_quo  (quo),
    .out_side (ser_div)
  );

  // table search
  ctl_t          ctl_srch;
  logic [SB-1:0] idx;
  logic [RW-1:0] res;

  tempc_srch #(
    .COUNT (COUNT),
    .FRAC  (FRACTION_BITS),
    .NW    (NW)
  ) u_srch (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_ctl    (ctl_div),
    .in_quo    (quo),
    .in_series (ser_div),
    .out_ctl   (ctl_srch),
    .out_idx   (idx),
    .out_res   (res)
  );

  // interpolation and output register
  tempc_interp #(
    .COUNT (COUNT),
    .FRAC  (FRACTION_BITS)
  ) u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_ctl     (ctl_srch),
    .in_idx     (idx),
    .in_res     (res),
    .out_valid  (out_valid),
    .out_temp   (out_temp_tenths),
    .out_status (out_status)
  );

endmodule

FILE: src/tempc_div.sv
// Pipelined restoring divider, a few quotient bits per stage.
module tempc_div #(
  parameter int NW     = 36,
  parameter int DW     = 12,
  parameter int SIDE_W = 16,
  parameter int K      = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  tempc_pkg::ctl_t    in_ctl,
  input  logic [NW-1:0]      in_num,
  input  logic [DW-1:0]      in_den,
  input  logic [SIDE_W-1:0]  in_side,
  output tempc_pkg::ctl_t    out_ctl,
  output logic [NW-1:0]      out_quo,
  output logic [SIDE_W-1:0]  out_side
);
  import tempc_pkg::*;

  localparam int NSTG = (NW + K - 1) / K;

  ctl_t              ctl_r  [NSTG];
  logic [NW-1:0]     dq_r   [NSTG];
  logic [DW-1:0]     rem_r  [NSTG];
  logic [DW-1:0]     den_r  [NSTG];
  logic [SIDE_W-1:0] side_r [NSTG];

  for (genvar j = 0; j < NSTG; j++) begin : g_stg
    ctl_t              ctl_in;
    logic [NW-1:0]     dq_in, dq_nxt;
    logic [DW-1:0]     rem_in, rem_nxt, den_in;
    logic [SIDE_W-1:0] side_in;

    if (j == 0) begin : g_first
      assign ctl_in  = in_ctl;
      assign dq_in   = in_num;
      assign rem_in  = '0;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign ctl_in  = ctl_r[j-1];
      assign dq_in   = dq_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign den_in  = den_r[j-1];
      assign side_in = side_r[j-1];
    end

    always_comb begin
      logic [DW:0] t;
      t       = '0;
      dq_nxt  = dq_in;
      rem_nxt = rem_in;
      for (int k = 0; k < K; k++) begin
        if (j * K + k < NW) begin
          t      = {rem_nxt, dq_nxt[NW-1]};
          dq_nxt = dq_nxt << 1;
          if (t >= {1'b0, den_in}) begin
            t         = t - {1'b0, den_in};
            dq_nxt[0] = 1'b1;
          end
          rem_nxt = t[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j] <= '0;
      end else if (en) begin
        ctl_r[j] <= ctl_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dq_r[j]   <= dq_nxt;
        rem_r[j]  <= rem_nxt;
        den_r[j]  <= den_in;
        side_r[j] <= side_in;
      end
    end
  end

  assign out_ctl  = ctl_r[NSTG-1];
  assign out_quo  = dq_r[NSTG-1];
  assign out_side = side_r[NSTG-1];

endmodule

FILE: src/tempc_srch.sv
// Resistance offset/clamp and pipelined binary search of the ROM.
module tempc_srch #(
  parameter int COUNT = 136,
  parameter int FRAC  = 8,
  parameter int NW    = 36
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      en,
  input  tempc_pkg::ctl_t                           in_ctl,
  input  logic [NW-1:0]                             in_quo,
  input  logic [tempc_pkg::SERIES_W-1:0]            in_series,
  output tempc_pkg::ctl_t                           out_ctl,
  output logic [$clog2(COUNT+1)-1:0]                out_idx,
  output logic [tempc_pkg::ROM_W+FRAC-1:0]          out_res
);
  import tempc_pkg::*;

  localparam int SB = $clog2(COUNT + 1);
  localparam int RW = ROM_W + FRAC;

  ctl_t          ctl_r [SB+1];
  logic [SB-1:0] idx_r [SB+1];
  logic [RW-1:0] res_r [SB+1];

  // offset by the series resistor, clamp into the ROM's range
  logic [NW:0]   r;
  logic [RW-1:0] rc;
  always_comb begin
    r = {1'b0, in_quo} - ((NW+1)'(in_series) << FRAC);
    if (r[NW]) begin
      rc = '0;
    end else if ((r[NW-1:0] >> RW) != '0) begin
      rc = '1;
    end else begin
      rc = r[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else if (en) begin
      ctl_r[0] <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r[0] <= '0;
      res_r[0] <= rc;
    end
  end

  // stage j decides index bit SB-j: count of entries above the resistance
  for (genvar j = 1; j <= SB; j++) begin : g_stg
    logic [SB:0]   cand;
    logic          take;
    logic [SB-1:0] idx_nxt;

    always_comb begin
      cand = (SB+1)'(idx_r[j-1]) + ((SB+1)'(1) << (SB - j));
      take = (cand <= (SB+1)'(COUNT)) &&
             ((RW'(rom_entry(ROM_IW'(cand - (SB+1)'(1)))) << FRAC) > res_r[j-1]);
      idx_nxt = take ? SB'(cand) : idx_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j] <= '0;
      end else if (en) begin
        ctl_r[j] <= ctl_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        idx_r[j] <= idx_nxt;
        res_r[j] <= res_r[j-1];
      end
    end
  end

  assign out_ctl = ctl_r[SB];
  assign out_idx = idx_r[SB];
  assign out_res = res_r[SB];

endmodule

FILE: src/tempc_interp.sv
// Linear interpolation between ROM entries, rounding and saturation.
module tempc_interp #(
  parameter int COUNT = 136,
  parameter int FRAC  = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  tempc_pkg::ctl_t                      in_ctl,
  input  logic [$clog2(COUNT+1)-1:0]           in_idx,
  input  logic [tempc_pkg::ROM_W+FRAC-1:0]     in_res,
  output logic                                 out_valid,
  output logic signed [tempc_pkg::TEMP_W-1:0]  out_temp,
  output logic [tempc_pkg::STATUS_W-1:0]       out_status
);
  import tempc_pkg::*;

  localparam int SB = $clog2(COUNT + 1);
  localparam int RW = ROM_W + FRAC;
  localparam int FW = ROM_W + FRAC + 7;
  localparam int GW = FW + 3;
  localparam int F_D_MUL = 5 << FRAC;
  localparam int G_D_MUL = 10 << FRAC;
  localparam logic signed [TEMP_W-1:0] TEMP_LOW  = TEMP_W'(TEMP_FIRST_C * 10);
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH = TEMP_W'((TEMP_FIRST_C + COUNT - 1) * 10);

  // stage A: bracket, numerator and denominator of the fractional part
  status_t                   st_a_nxt;
  logic signed [TEMP_W-1:0]  pre_a_nxt, t10_a_nxt;
  logic [ROM_W-1:0]          hi, lo, dd;
  logic [RW-1:0]             nn;
  logic [GW-1:0]             f_a_nxt, g_a_nxt;

  always_comb begin
    hi = rom_entry(ROM_IW'(in_idx - SB'(1)));
    lo = rom_entry(ROM_IW'(in_idx));
    dd = hi - lo;
    nn = (RW'(hi) << FRAC) - in_res;
    f_a_nxt = GW'(FW'(dd) * FW'(F_D_MUL) + FW'(nn) * FW'(100));
    g_a_nxt = GW'(FW'(dd) * FW'(G_D_MUL));
    t10_a_nxt = TEMP_W'($signed({1'b0, in_idx}) * 10 + (TEMP_FIRST_C - 1) * 10);
    pre_a_nxt = '0;
    if (in_ctl.zero) begin
      st_a_nxt = ST_ZERO;
    end else if (in_idx == '0) begin
      st_a_nxt  = ST_BELOW;
      pre_a_nxt = TEMP_LOW;
    end else if (in_idx >= SB'(COUNT)) begin
      st_a_nxt  = ST_ABOVE;
      pre_a_nxt = TEMP_HIGH;
    end else begin
      st_a_nxt = ST_OK;
    end
  end

  logic                      v_a_r, v_b_r, v_c_r, v_d_r;
  status_t                   st_a_r, st_b_r, st_c_r;
  logic signed [TEMP_W-1:0]  pre_a_r, pre_b_r, pre_c_r;
  logic signed [TEMP_W-1:0]  t10_a_r, t10_b_r, t10_c_r;
  logic                      flat_a_r, flat_b_r, flat_c_r;
  logic [GW-1:0]             f_a_r, g_a_r, f_b_r, g_b_r, f_c_r;
  logic [1:0]                q_b_r;
  logic [3:0]                q_c_r;
  logic signed [TEMP_W-1:0]  temp_d_r;
  status_t                   st_d_r;

  // stages B and C: quotient bits 3..2 then 1..0 of F / G (value 0..10)
  logic [GW-1:0] f_b_nxt, f_c_nxt;
  logic [1:0]    q_b_nxt, q_c_lo;
  always_comb begin
    f_b_nxt = f_a_r;
    q_b_nxt = '0;
    for (int k = 3; k >= 2; k--) begin
      if (f_b_nxt >= (g_a_r << k)) begin
        f_b_nxt = f_b_nxt - (g_a_r << k);
        q_b_nxt[k-2] = 1'b1;
      end
    end
    f_c_nxt = f_b_r;
    q_c_lo  = '0;
    for (int k = 1; k >= 0; k--) begin
      if (f_c_nxt >= (g_b_r << k)) begin
        f_c_nxt = f_c_nxt - (g_b_r << k);
        q_c_lo[k] = 1'b1;
      end
    end
  end

  // stage D: truncate toward zero; pick the saturated or zero value for the edge cases, t10 if flat
  logic signed [TEMP_W:0]   sum;
  logic signed [TEMP_W-1:0] temp_d_nxt;
  always_comb begin
    sum = {t10_c_r[TEMP_W-1], t10_c_r} + $signed({{(TEMP_W-3){1'b0}}, q_c_r});
    if (sum < 0 && f_c_r != '0) begin
      sum = sum + (TEMP_W+1)'(1);
    end
    if (st_c_r != ST_OK) begin
      temp_d_nxt = pre_c_r;
    end else if (flat_c_r) begin
      temp_d_nxt = t10_c_r;
    end else begin
      temp_d_nxt = sum[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
    end else if (en) begin
      v_a_r <= in_ctl.valid;
      v_b_r <= v_a_r;
      v_c_r <= v_b_r;
      v_d_r <= v_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_a_r   <= st_a_nxt;
      pre_a_r  <= pre_a_nxt;
      t10_a_r  <= t10_a_nxt;
      flat_a_r <= (dd == '0);
      f_a_r    <= f_a_nxt;
      g_a_r    <= g_a_nxt;

      st_b_r   <= st_a_r;
      pre_b_r  <= pre_a_r;
      t10_b_r  <= t10_a_r;
      flat_b_r <= flat_a_r;
      f_b_r    <= f_b_nxt;
      g_b_r    <= g_a_r;
      q_b_r    <= q_b_nxt;

      st_c_r   <= st_b_r;
      pre_c_r  <= pre_b_r;
      t10_c_r  <= t10_b_r;
      flat_c_r <= flat_b_r;
      f_c_r    <= f_c_nxt;
      q_c_r    <= {q_b_r, q_c_lo};

      st_d_r   <= st_c_r;
      temp_d_r <= temp_d_nxt;
    end
  end

  assign out_valid  = v_d_r;
  assign out_temp   = temp_d_r;
  assign out_status = st_d_r;

endmodule
